/* rtl/tkpq_pkg.sv */
// types, codes and key compare shared by the priority queue modules
`default_nettype none

package tkpq_pkg;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_POP    = 1'b1;

   localparam int KEY_W   = 16;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 5;

   typedef struct packed {
      logic                    action;
      logic signed [KEY_W-1:0] primary_key;
      logic signed [KEY_W-1:0] secondary_key;
      logic [TAG_W-1:0]        payload;
   } tkpq_req_type;

   typedef struct packed {
      logic                    accepted;
      logic                    head_valid;
      logic signed [KEY_W-1:0] head_primary;
      logic signed [KEY_W-1:0] head_secondary;
      logic [TAG_W-1:0]        head_payload;
      logic [COUNT_W-1:0]      entry_count;
   } tkpq_rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] primary_key;
      logic signed [KEY_W-1:0] secondary_key;
      logic [TAG_W-1:0]        payload;
   } tkpq_entry_type;

   // shift commands broadcast to every cell
   typedef struct packed {
      logic insert_en;
      logic pop_en;
   } tkpq_ctrl_type;

   // stored key pair is not smaller than the new key pair
   function automatic logic not_smaller(input tkpq_entry_type stored,
                                        input tkpq_entry_type incoming);
      logic result;
      if (stored.primary_key != incoming.primary_key) begin
         result = $signed(stored.primary_key) > $signed(incoming.primary_key);
      end else begin
         result = $signed(stored.secondary_key) >= $signed(incoming.secondary_key);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

/* rtl/two_key_sorted_priority_queue.sv */
// top level of the two-key sorted priority queue built from a row of shifting cells
`default_nettype none

// Sorted priority queue of up to CAPACITY entries, ordered ascending by the
// signed primary key and then the signed secondary key; a new entry goes
// ahead of stored entries with equal keys. A transaction is taken when start
// is high and busy is low. busy never rises: every cell compares the new key
// pair against its own entry and shifts in the same cycle, so one insert or
// pop is taken every clock. The result for a transaction appears on rsp_item
// with rsp_valid high for exactly one cycle, the cycle after acceptance, and
// reports the head entry and the count after that transaction. The receiver
// cannot stall the result. An insert into a full queue or a pop of an empty
// queue is refused with accepted low and leaves the queue unchanged. Head
// fields read zero when the queue is empty. No clearing pass after reset.
module two_key_sorted_priority_queue
   import tkpq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire tkpq_req_type req_item,
   output logic              rsp_valid,
   output tkpq_rsp_type      rsp_item
);

   localparam int CountW = $clog2(CAPACITY + 1);
   localparam logic [CountW-1:0] CapacityValue = CountW'(CAPACITY);
   localparam logic [CountW-1:0] CountOne      = CountW'(1);

   // control state
   logic [CountW-1:0] count_ff, count_in;
   logic              rsp_valid_ff;
   logic              accepted_ff;

   logic              take;
   tkpq_ctrl_type     ctrl;
   tkpq_entry_type    new_entry;

   tkpq_entry_type    cell_entry [CAPACITY];
   logic              cell_place [CAPACITY];

   assign busy = 1'b0;
   assign take = start && !busy;

   // refused transactions leave the row untouched
   assign ctrl.insert_en = take && (req_item.action == ACT_INSERT) && (count_ff < CapacityValue);
   assign ctrl.pop_en    = take && (req_item.action == ACT_POP) && (count_ff != '0);

   assign new_entry.primary_key   = req_item.primary_key;
   assign new_entry.secondary_key = req_item.secondary_key;
   assign new_entry.payload       = req_item.payload;

   // row of cells, head at index zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      tkpq_entry_type left_entry;
      tkpq_entry_type right_entry;
      logic           left_place;

      if (i == 0) begin : g_head
         assign left_place = 1'b0;
         assign left_entry = new_entry;
      end else begin : g_body
         assign left_place = cell_place[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         // tail slot is vacated by a pop, its content no longer matters
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      tkpq_cell #(
         .INDEX       (i),
         .COUNT_WIDTH (CountW)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .new_entry   (new_entry),
         .left_place  (left_place),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .place       (cell_place[i]),
         .entry       (cell_entry[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CountOne;
      end else if (ctrl.pop_en) begin
         count_in = count_ff - CountOne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= take;
         accepted_ff  <= ctrl.insert_en || ctrl.pop_en;
      end
   end

   // result reads the row as it stands after the transaction
   logic head_valid;
   assign head_valid = count_ff != '0;

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_item.accepted       = accepted_ff;
   assign rsp_item.head_valid     = head_valid;
   assign rsp_item.head_primary   = head_valid ? cell_entry[0].primary_key   : '0;
   assign rsp_item.head_secondary = head_valid ? cell_entry[0].secondary_key : '0;
   assign rsp_item.head_payload   = head_valid ? cell_entry[0].payload       : '0;
   // low bits of the count only when the count is wider than the field
   assign rsp_item.entry_count    = COUNT_W'(count_ff);

   // count stays within the row
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapacityValue)
      else $error("entry count above capacity");

   // a result only follows a taken transaction, accepted or refused
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take))
      else $error("result without transaction");

   // a done insert raises the count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert_en |=> (count_ff == $past(count_ff) + CountOne) && rsp_item.accepted)
      else $error("insert did not grow the queue");

   // a done pop lowers the count by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop_en |=> (count_ff == $past(count_ff) - CountOne) && rsp_item.accepted)
      else $error("pop did not shrink the queue");

endmodule

`default_nettype wire

/* rtl/tkpq_cell.sv */
// one slot of the sorted row: holds an entry and shifts with its neighbors
`default_nettype none

module tkpq_cell
   import tkpq_pkg::*;
#(
   parameter int INDEX       = 0,
   parameter int COUNT_WIDTH = 5
) (
   input  wire logic                   clock,
   input  wire tkpq_ctrl_type          ctrl,
   input  wire logic [COUNT_WIDTH-1:0] count,
   input  wire tkpq_entry_type         new_entry,
   input  wire logic                   left_place,
   input  wire tkpq_entry_type         left_entry,
   input  wire tkpq_entry_type         right_entry,
   output logic                        place,
   output tkpq_entry_type              entry
);

   localparam logic [COUNT_WIDTH-1:0] IndexValue = COUNT_WIDTH'(INDEX);

   tkpq_entry_type entry_ff, entry_in;
   logic           occupied;

   assign occupied = count > IndexValue;
   // free slots count as not smaller, so the new entry lands at the first one
   assign place    = !occupied || not_smaller(entry_ff, new_entry);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en && place) begin
         entry_in = left_place ? left_entry : new_entry;
      end else if (ctrl.pop_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
